// ===== rtl/core/crcpic_pkg.sv =====
// Package for the CRC-32 packet integrity checker: transaction types,
// CRC constants and the byte-wide reflected CRC update function.
// No dependencies.
`default_nettype none

package crcpic_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT   = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [2:0]  HEADER_BYTES = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] computed_crc;
    logic        crc_match;
    logic [31:0] mismatch_count;
  } out_item_t;

  // Reflected CRC-32, one byte: eight shift/xor steps, flattened to an xor tree
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcpic_engine.sv =====
// Packet state and per-byte work: header capture, CRC update, match and
// saturating mismatch count. Depends on crcpic_pkg.
`default_nettype none

module crcpic_engine (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  wire crcpic_pkg::in_item_t item,
  output crcpic_pkg::out_item_t res
);

  logic [31:0] running_crc_r, running_crc_nxt;
  logic [31:0] stored_crc_r,  stored_crc_nxt;
  logic [2:0]  hdr_pos_r,     hdr_pos_nxt;
  logic [31:0] failed_r,      failed_nxt;

  logic        in_header;
  logic [31:0] crc_upd;
  logic [31:0] stored_upd;
  logic [31:0] computed;
  logic        match;

  assign in_header  = (hdr_pos_r < crcpic_pkg::HEADER_BYTES);
  assign stored_upd = in_header
                    ? (stored_crc_r | ({24'd0, item.data_byte} << {hdr_pos_r[1:0], 3'b000}))
                    : stored_crc_r;
  assign crc_upd    = in_header ? running_crc_r
                                : crcpic_pkg::crc_byte(running_crc_r, item.data_byte);
  assign computed   = crc_upd ^ crcpic_pkg::CRC_XOROUT;
  assign match      = (computed == stored_upd);

  always_comb begin
    running_crc_nxt = running_crc_r;
    stored_crc_nxt  = stored_crc_r;
    hdr_pos_nxt     = hdr_pos_r;
    failed_nxt      = failed_r;
    if (fire) begin
      if (item.last_byte) begin
        // rearm for the next packet
        running_crc_nxt = crcpic_pkg::CRC_INIT;
        stored_crc_nxt  = 32'd0;
        hdr_pos_nxt     = 3'd0;
        if (!match && (failed_r != crcpic_pkg::COUNT_MAX)) begin
          failed_nxt = failed_r + 32'd1;
        end
      end else begin
        running_crc_nxt = crc_upd;
        stored_crc_nxt  = stored_upd;
        hdr_pos_nxt     = in_header ? (hdr_pos_r + 3'd1) : hdr_pos_r;
      end
    end
  end

  always_comb begin
    res.computed_crc = computed;
    res.crc_match    = match;
    res.mismatch_count = (!match && (failed_r != crcpic_pkg::COUNT_MAX))
                       ? (failed_r + 32'd1) : failed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_crc_r <= crcpic_pkg::CRC_INIT;
      stored_crc_r  <= 32'd0;
      hdr_pos_r     <= 3'd0;
      failed_r      <= 32'd0;
    end else begin
      running_crc_r <= running_crc_nxt;
      stored_crc_r  <= stored_crc_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      failed_r      <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crc32_packet_integrity_check_core.sv =====
// Top level of the CRC-32 packet integrity checker: input register, packet
// engine and result register. Depends on crcpic_pkg and crcpic_engine.
//
//   channel  direction  payload       transaction
//   in       in         in_item_t     one packet byte, last flag
//   out      out        out_item_t    one result per packet, on the last byte
//
// One byte per cycle sustained while the result register has room for a last byte; a last
// byte's result is written to the result register, the CRC step sitting between the two registers.
// Synchronous active-low reset clears packet state and the mismatch count.
// A stalled result only holds back a last byte behind it; other bytes flow on.
`default_nettype none

module crc32_packet_integrity_check_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire crcpic_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output crcpic_pkg::out_item_t out_data
);

  logic                  in_valid_r, in_valid_nxt;
  crcpic_pkg::in_item_t  in_item_r;
  logic                  out_valid_r, out_valid_nxt;
  crcpic_pkg::out_item_t out_data_r;
  crcpic_pkg::out_item_t res;

  logic advance;
  logic accept_in;
  logic res_fire;

  // a last byte needs room in the result register
  assign advance   = in_valid_r && (!in_item_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;
  assign res_fire  = advance && in_item_r.last_byte;

  crcpic_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept_in) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_item_r <= in_data;
    end
    if (res_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== bench/tb_crc32_packet_integrity_check_core.sv =====
// Self-checking bench for crc32_packet_integrity_check_core: packet stimulus with
// bursty sender and stalling receiver, verdicts predicted by a local CRC-32 tracker.
// Depends on crcpic_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_crc32_packet_integrity_check_core;

  localparam logic [31:0] POLY_REFL      = 32'hEDB8_8320;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          TOTAL_BYTES    = 630;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        known;
    logic [31:0] crc;
    logic        match;
    logic [31:0] count;
  } dir_row_t;

  localparam int N_DIR = 27;
  // directed packets: single-byte packets, bare header, short header,
  // the standard check string with its CRC in the header, all-ones header
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 32'd0},
    '{8'hFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'd1},
    '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 32'd1},
    '{8'h12, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h34, 1'b1, 1'b1, 32'h0000_0000, 1'b0, 32'd2},
    '{8'h26, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h39, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hF4, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hCB, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h31, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h32, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h33, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h34, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h35, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h36, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h37, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h38, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h39, 1'b1, 1'b1, 32'hCBF4_3926, 1'b1, 32'd2},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b0, 32'h0, 1'b0, 32'd0},
    '{8'hFF, 1'b1, 1'b0, 32'h0, 1'b0, 32'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  crcpic_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  crcpic_pkg::out_item_t out_data;

  crcpic_pkg::out_item_t crc_verdicts_q [$];
  crcpic_pkg::out_item_t want;

  // local copy of the checker state
  logic [31:0] trk_crc     = 32'hFFFF_FFFF;
  logic [31:0] trk_hdr     = 32'h0;
  logic [2:0]  trk_hdr_pos = 3'd0;
  logic [31:0] trk_fails   = 32'h0;

  int  fail_count    = 0;
  int  bytes_offered = 0;
  int  burst_left    = 0;
  int  gap_max       = 0;
  int  stall_pct     = 0;
  int  idle_cycles   = 0;
  bit  hold_req      = 1'b0;

  crc32_packet_integrity_check_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bit-serial reflected CRC step, one data bit at a time
  function automatic logic [31:0] crc32_feed(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[31:1]} ^ (fb ? POLY_REFL : 32'h0);
    end
    return r;
  endfunction

  // advance the tracked state by one byte; queue the verdict on a last byte
  task automatic track_packet_byte(input crcpic_pkg::in_item_t it, input bit known,
                                   input crcpic_pkg::out_item_t typed);
    crcpic_pkg::out_item_t res;
    if (trk_hdr_pos < 3'd4) begin
      trk_hdr     = trk_hdr | ({24'h0, it.data_byte} << (8 * trk_hdr_pos));
      trk_hdr_pos = trk_hdr_pos + 3'd1;
    end else begin
      trk_crc = crc32_feed(trk_crc, it.data_byte);
    end
    if (it.last_byte) begin
      res.computed_crc = ~trk_crc;
      res.crc_match    = (~trk_crc == trk_hdr);
      if (!res.crc_match && trk_fails != 32'hFFFF_FFFF) begin
        trk_fails = trk_fails + 32'd1;
      end
      res.mismatch_count = trk_fails;
      crc_verdicts_q.push_back(known ? typed : res);
      trk_crc     = 32'hFFFF_FFFF;
      trk_hdr     = 32'h0;
      trk_hdr_pos = 3'd0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input crcpic_pkg::in_item_t it, input bit known,
                           input crcpic_pkg::out_item_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    track_packet_byte(it, known, typed);
    bytes_offered++;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // hdr_len < 4 gives a short packet with no payload
  task automatic send_packet(input int hdr_len, input int pay_len, input bit corrupt);
    logic [7:0]            pay [$];
    logic [31:0]           c;
    logic [31:0]           hdr;
    crcpic_pkg::in_item_t  it;
    c = 32'hFFFF_FFFF;
    if (hdr_len < 4) begin
      pay_len = 0;
    end
    for (int i = 0; i < pay_len; i++) begin
      pay.push_back(8'($urandom));
      c = crc32_feed(c, pay[i]);
    end
    hdr = (corrupt || hdr_len < 4) ? $urandom : ~c;
    for (int i = 0; i < hdr_len; i++) begin
      it.data_byte = hdr[8*i +: 8];
      it.last_byte = (i == hdr_len - 1) && (pay_len == 0);
      send_byte(it, 1'b0, '0);
    end
    for (int i = 0; i < pay_len; i++) begin
      it.data_byte = pay[i];
      it.last_byte = (i == pay_len - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  task automatic send_random_packets(input int byte_goal);
    int r;
    while (bytes_offered < byte_goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_packet(4, $urandom_range(0, 12), 1'b0);
      end else if (r < 80) begin
        send_packet(4, $urandom_range(0, 12), 1'b1);
      end else if (r < 92) begin
        send_packet($urandom_range(1, 4), 0, 1'b1);
      end else begin
        send_packet(4, $urandom_range(13, 64), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // receiver: stall runs of random length, plus a long hold-off on request
  initial begin
    int run_left;
    bit stalled;
    run_left  = 0;
    stalled   = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_stall <= 1'b0;
        run_left  = 0;
      end else begin
        if (run_left == 0) begin
          stalled  = ($urandom_range(0, 99) < stall_pct);
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        out_stall <= stalled;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crc_verdicts_q.size() == 0) begin
        $error("unexpected result transaction: crc %h match %b count %0d",
               out_data.computed_crc, out_data.crc_match, out_data.mismatch_count);
        fail_count++;
      end else begin
        want = crc_verdicts_q.pop_front();
        if (out_data.computed_crc !== want.computed_crc) begin
          $error("computed_crc: expected %h, got %h", want.computed_crc, out_data.computed_crc);
          fail_count++;
        end
        if (out_data.crc_match !== want.crc_match) begin
          $error("crc_match: expected %b, got %b", want.crc_match, out_data.crc_match);
          fail_count++;
        end
        if (out_data.mismatch_count !== want.mismatch_count) begin
          $error("mismatch_count: expected %0d, got %0d", want.mismatch_count,
                 out_data.mismatch_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL crc32_packet_integrity_check_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    crcpic_pkg::in_item_t  it;
    crcpic_pkg::out_item_t typed;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, no idling on either side
    for (int i = 0; i < N_DIR; i++) begin
      it.data_byte         = DIR_ROWS[i].data_byte;
      it.last_byte         = DIR_ROWS[i].last_byte;
      typed.computed_crc   = DIR_ROWS[i].crc;
      typed.crc_match      = DIR_ROWS[i].match;
      typed.mismatch_count = DIR_ROWS[i].count;
      send_byte(it, DIR_ROWS[i].known, typed);
    end

    gap_max   = 6;
    stall_pct = 30;
    send_random_packets(230);

    // long receiver hold-off while short packets keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_packet($urandom_range(1, 4), 0, 1'b1);
    end
    for (int i = 0; i < 4; i++) begin
      send_packet(4, $urandom_range(0, 3), 1'b0);
    end

    // drain completely before carrying on
    in_valid <= 1'b0;
    do @(negedge clk); while (crc_verdicts_q.size() != 0);

    gap_max   = 0;
    stall_pct = 0;
    send_random_packets(380);

    gap_max   = 10;
    stall_pct = 60;
    send_random_packets(TOTAL_BYTES);

    in_valid <= 1'b0;
    while (crc_verdicts_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS crc32_packet_integrity_check_core");
    end else begin
      $display("FAIL crc32_packet_integrity_check_core");
    end
    $finish;
  end

endmodule
